>>> hdl/r332d_pkg.sv
// Package for the RGBA to RGB332 dither unit: config codes, thresholds, quantiser functions.
package r332d_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned WIDTH_W   = 13;
    localparam int unsigned COL_W     = 12;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned MAX_WIDTH = 4096;

    localparam logic [WIDTH_W-1:0] MAX_WIDTH_VAL   = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET_VAL = WIDTH_W'(256);
    localparam logic [PIX_W-1:0]   ALPHA_OPAQUE    = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_CODE = 8'd2;

    // Level k reached when v >= threshold[k-1].
    // Rounding thresholds also match the ceiled-then-halved dither path.
    localparam logic [PIX_W-1:0] RG_ROUND_THR [7] = '{8'd19, 8'd55, 8'd92, 8'd128,
                                                      8'd164, 8'd201, 8'd237};
    localparam logic [PIX_W-1:0] RG_FLOOR_THR [7] = '{8'd37, 8'd73, 8'd110, 8'd146,
                                                      8'd183, 8'd219, 8'd255};
    localparam logic [PIX_W-1:0] B_FLOOR_THR  [3] = '{8'd85, 8'd170, 8'd255};
    localparam logic [PIX_W-1:0] B_CEIL_THR   [3] = '{8'd43, 8'd128, 8'd213};

    typedef struct packed {
        logic             dither_enable;
        logic             round_up;
        logic [PIX_W-1:0] transparent_code;
    } quant_ctrl_t;

    function automatic logic [2:0] rg_level(input logic [PIX_W-1:0] v, input logic use_round);
        logic [2:0] lvl;
        lvl = 3'd0;
        for (int k = 0; k < 7; k++) begin
            if (v >= (use_round ? RG_ROUND_THR[k] : RG_FLOOR_THR[k])) begin
                lvl = lvl + 3'd1;
            end
        end
        return lvl;
    endfunction

    function automatic logic [1:0] b_level(input logic [PIX_W-1:0] v, input logic use_ceil);
        logic [1:0] lvl;
        lvl = 2'd0;
        for (int k = 0; k < 3; k++) begin
            if (v >= (use_ceil ? B_CEIL_THR[k] : B_FLOOR_THR[k])) begin
                lvl = lvl + 2'd1;
            end
        end
        return lvl;
    endfunction

endpackage

>>> hdl/r332d_quant.sv
// Per-pixel quantiser: RGBA to 3-3-2 palette byte, plain or checkerboard dithered.
module r332d_quant
    import r332d_pkg::*;
(
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    input  logic [PIX_W-1:0] alpha,
    input  quant_ctrl_t      ctrl,
    output logic [PIX_W-1:0] palette_byte
);

    logic use_round;
    logic b_ceil;

    // for red and green, plain rounding and the ceil phase of the dither share thresholds
    assign use_round = !ctrl.dither_enable || ctrl.round_up;
    assign b_ceil    = ctrl.dither_enable && ctrl.round_up;

    always_comb begin
        if (alpha != ALPHA_OPAQUE) begin
            palette_byte = ctrl.transparent_code;
        end else begin
            palette_byte = {rg_level(red, use_round), rg_level(green, use_round),
                            b_level(blue, b_ceil)};
        end
    end

endmodule

>>> hdl/rgba_to_rgb332_dither_unit.sv
// Top level: RGBA pixel stream to RGB332 palette bytes with position tracking and config.
//
//  Channel  Dir  Handshake              Payload
//  s_       in   s_valid / s_ready      s_red, s_green, s_blue, s_alpha
//  m_       out  m_valid / m_ready      m_palette_byte
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One pixel per cycle unless m_ready stalls the output; a result appears in the cycle after its beat is accepted.
// The quantiser sits between the input handshake and the output register.
// s_ready is high while the output register is empty or being drained this cycle.
// cfg_ready is always high. Reset restores config defaults and clears the position.
module rgba_to_rgb332_dither_unit
    import r332d_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_red,
    input  logic [PIX_W-1:0]     s_green,
    input  logic [PIX_W-1:0]     s_blue,
    input  logic [PIX_W-1:0]     s_alpha,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PIX_W-1:0]     m_palette_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_data
);

    logic               dither_enable_reg;
    logic [WIDTH_W-1:0] image_width_reg;
    logic [PIX_W-1:0]   transparent_code_reg;
    logic [COL_W-1:0]   column_count_reg;
    logic [COL_W-1:0]   column_count_next;
    logic               row_parity_reg;
    logic               row_parity_next;
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_byte_reg;

    logic               s_beat;
    logic               cfg_beat;
    logic [WIDTH_W-1:0] width_eff;
    logic [WIDTH_W-1:0] col_plus_one;
    quant_ctrl_t        qctrl;
    logic [PIX_W-1:0]   q_byte;

    assign s_ready   = !out_valid_reg || m_ready;
    assign s_beat    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid;

    assign m_valid        = out_valid_reg;
    assign m_palette_byte = out_byte_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_enable_reg    <= 1'b0;
            image_width_reg      <= WIDTH_RESET_VAL;
            transparent_code_reg <= '0;
        end else if (cfg_beat) begin
            unique case (cfg_index)
                REG_DITHER_ENABLE:    dither_enable_reg    <= cfg_data[0];
                REG_IMAGE_WIDTH:      image_width_reg      <= cfg_data;
                REG_TRANSPARENT_CODE: transparent_code_reg <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // width of 0 acts as 1, above the maximum acts as the maximum
    always_comb begin
        if (image_width_reg == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (image_width_reg > MAX_WIDTH_VAL) begin
            width_eff = MAX_WIDTH_VAL;
        end else begin
            width_eff = image_width_reg;
        end
    end

    assign col_plus_one = {1'b0, column_count_reg} + WIDTH_W'(1);

    always_comb begin
        if (col_plus_one >= width_eff) begin
            column_count_next = '0;
            row_parity_next   = !row_parity_reg;
        end else begin
            column_count_next = col_plus_one[COL_W-1:0];
            row_parity_next   = row_parity_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_parity_reg   <= 1'b0;
        end else if (s_beat) begin
            column_count_reg <= column_count_next;
            row_parity_reg   <= row_parity_next;
        end
    end

    assign qctrl.dither_enable    = dither_enable_reg;
    assign qctrl.round_up         = row_parity_reg ^ column_count_reg[0];
    assign qctrl.transparent_code = transparent_code_reg;

    r332d_quant u_quant (
        .red          (s_red),
        .green        (s_green),
        .blue         (s_blue),
        .alpha        (s_alpha),
        .ctrl         (qctrl),
        .palette_byte (q_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_ready) begin
            out_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            out_byte_reg <= q_byte;
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for rgba_to_rgb332_dither_unit: palette predictor class, stimulus tasks, top.
module tb;
    import r332d_pkg::*;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned LONG_HOLD    = 64;
    localparam int unsigned TOTAL_PIXELS = 1650;
    localparam int unsigned CALM_PIXELS  = 150;

    // Works out the palette byte of every accepted pixel and keeps the bytes still owed.
    class rgb332_predictor;
        bit                   dither_on;
        logic [WIDTH_W-1:0]   width_reg;
        logic [PIX_W-1:0]     transp_code;
        int unsigned          column;
        bit                   row_odd;
        logic [PIX_W-1:0]     owed_bytes[$];
        int unsigned          errors;

        function new();
            dither_on   = 1'b0;
            width_reg   = WIDTH_W'(256);
            transp_code = '0;
            column      = 0;
            row_odd     = 1'b0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] data);
            case (idx)
                REG_DITHER_ENABLE:    dither_on   = data[0];
                REG_IMAGE_WIDTH:      width_reg   = data;
                REG_TRANSPARENT_CODE: transp_code = data[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned q, int unsigned top);
            return (q > top) ? top : q;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                 logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
            int unsigned eff_w;
            int unsigned qr, qg, qb;
            bit          up;
            logic [PIX_W-1:0] pb;
            eff_w = 32'(width_reg);
            if (eff_w < 1) eff_w = 1;
            if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
            up = row_odd != column[0];
            if (a != ALPHA_OPAQUE) begin
                pb = transp_code;
            end else if (!dither_on) begin
                // round(v / 36.428) done as (2000v + 36428) / 72856
                qr = clamp((2000 * r + 36428) / 72856, 7);
                qg = clamp((2000 * g + 36428) / 72856, 7);
                qb = b / 85;
                pb = {qr[2:0], qg[2:0], qb[1:0]};
            end else begin
                qr = up ? (1000 * r + 18213) / 18214 : (1000 * r) / 18214;
                qg = up ? (1000 * g + 18213) / 18214 : (1000 * g) / 18214;
                qb = up ? (2 * b + 84) / 85 : (2 * b) / 85;
                qr = clamp(qr >> 1, 7);
                qg = clamp(qg >> 1, 7);
                qb = clamp(qb >> 1, 3);
                pb = {qr[2:0], qg[2:0], qb[1:0]};
            end
            owed_bytes.push_back(pb);
            if (column + 1 >= eff_w) begin
                column  = 0;
                row_odd = !row_odd;
            end else begin
                column = column + 1;
            end
        endfunction

        function void check_byte(logic [PIX_W-1:0] got);
            logic [PIX_W-1:0] want;
            if (owed_bytes.size() == 0) begin
                errors++;
                $display("%0t: palette byte with none owed: expected none, actual %h",
                         $time, got);
            end else begin
                want = owed_bytes.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: palette_byte: expected %h, actual %h", $time, want, got);
                end
            end
        endfunction

        function int unsigned owed();
            return owed_bytes.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_red;
    logic [PIX_W-1:0]     s_green;
    logic [PIX_W-1:0]     s_blue;
    logic [PIX_W-1:0]     s_alpha;
    logic                 m_valid;
    logic                 m_ready;
    logic [PIX_W-1:0]     m_palette_byte;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIDTH_W-1:0]   cfg_data;

    rgb332_predictor pred = new();

    int unsigned pixels_sent    = 0;
    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 20;
    bit          hold_req       = 1'b0;
    int unsigned quiet_cycles   = 0;

    rgba_to_rgb332_dither_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_alpha        (s_alpha),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_palette_byte (m_palette_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Monitor and watchdog. Input beat noted before the result check so order is kept.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                pred.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                pred.note_pixel(s_red, s_green, s_blue, s_alpha);
            if (m_valid && m_ready)
                pred.check_byte(m_palette_byte);
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("rgba_to_rgb332_dither_unit: mismatch");
                $finish;
            end
        end
    end

    // Result side back-pressure
    initial begin
        int unsigned n;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if ($urandom_range(0, 99) < recv_stall_pct) begin
                n = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Leaves s_valid high on return; the caller drops it once the burst is done.
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] a);
        int unsigned gap;
        if ($urandom_range(0, 99) < send_gap_pct) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_red   <= r;
        s_green <= g;
        s_blue  <= b;
        s_alpha <= a;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_pixel();
        logic [PIX_W-1:0] a;
        case ($urandom_range(0, 9))
            0:       a = ALPHA_OPAQUE - PIX_W'(1);
            1:       a = 8'h00;
            2:       a = PIX_W'($urandom_range(0, 255));
            default: a = ALPHA_OPAQUE;
        endcase
        send_pixel(pick_level(), pick_level(), pick_level(), a);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (pred.owed() != 0);
    endtask

    // All three registers, plus now and then a write to an unused index.
    task automatic write_regs(input logic [WIDTH_W-1:0] dither_data,
                              input logic [WIDTH_W-1:0] width_data,
                              input logic [WIDTH_W-1:0] transp_data);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DITHER_ENABLE;
        cfg_data  <= dither_data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= width_data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_TRANSPARENT_CODE;
        cfg_data  <= transp_data;
        do @(posedge aclk); while (!cfg_ready);
        if ($urandom_range(0, 2) == 0) begin
            cfg_index <= REG_TRANSPARENT_CODE + CFG_IDX_W'(1)
                         + CFG_IDX_W'($urandom_range(0, 252));
            cfg_data  <= WIDTH_W'($urandom_range(0, 8191));
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic configure_phase(input int unsigned phase_no);
        logic [WIDTH_W-1:0] w;
        logic [WIDTH_W-1:0] tc;
        logic               dith;
        case (phase_no)
            0:       w = '0;
            1:       w = WIDTH_W'(1);
            2:       w = WIDTH_W'(3);
            3:       w = MAX_WIDTH_VAL;
            4:       w = MAX_WIDTH_VAL + WIDTH_W'(1);
            5:       w = '1;
            default: w = ($urandom_range(0, 5) == 0) ? WIDTH_W'($urandom_range(13, 300))
                                                     : WIDTH_W'($urandom_range(1, 12));
        endcase
        dith = (phase_no < 6) ? phase_no[0] : 1'($urandom_range(0, 1));
        tc   = WIDTH_W'($urandom_range(0, 8191));
        if (phase_no == 2) tc[PIX_W-1:0] = 8'hFF;
        if (phase_no == 3) tc[PIX_W-1:0] = 8'h00;
        // upper bits of the enable data carry junk
        write_regs({(WIDTH_W-1)'($urandom_range(0, 4095)), dith}, w, tc);
    endtask

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 40;
        endcase
    endfunction

    initial begin
        int unsigned phase_no;
        int unsigned phase_len;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_red     <= '0;
        s_green   <= '0;
        s_blue    <= '0;
        s_alpha   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Plain rounding from reset defaults: extremes and level edges
        send_pixel(8'd0,   8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd18,  8'd54,  8'd84,  8'd255);
        send_pixel(8'd19,  8'd55,  8'd85,  8'd255);
        send_pixel(8'd127, 8'd128, 8'd169, 8'd255);
        send_pixel(8'd236, 8'd237, 8'd170, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd254);
        send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
        s_valid <= 1'b0;
        wait_drained();

        // Dithered, two-pixel rows so each checkerboard phase is hit
        write_regs(WIDTH_W'(1), WIDTH_W'(2), WIDTH_W'(8'hA5));
        repeat (4) send_pixel(8'd36, 8'd37, 8'd42, 8'd255);
        repeat (4) send_pixel(8'd37, 8'd73, 8'd43, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd0,   8'd0,   8'd255);
        send_pixel(8'd146, 8'd18,  8'd128, 8'd255);
        send_pixel(8'd219, 8'd110, 8'd213, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        s_valid <= 1'b0;

        phase_no = 0;
        while (pixels_sent < TOTAL_PIXELS - CALM_PIXELS) begin
            wait_drained();
            configure_phase(phase_no);
            send_gap_pct   = pick_pct();
            recv_stall_pct = pick_pct();
            // sink blocks for a while and the unit backs up into the source
            if (phase_no == 1 || $urandom_range(0, 4) == 0)
                hold_req = 1'b1;
            phase_len = $urandom_range(40, 160);
            repeat (phase_len) random_pixel();
            s_valid <= 1'b0;
            phase_no++;
        end

        // closing stretch at full rate
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        wait_drained();
        configure_phase(phase_no);
        repeat (CALM_PIXELS) random_pixel();
        s_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge aclk);
        if (pred.errors == 0 && pred.owed() == 0)
            $display("rgba_to_rgb332_dither_unit: match");
        else
            $display("rgba_to_rgb332_dither_unit: mismatch");
        $finish;
    end

endmodule

>>> rgba_to_rgb332_dither_unit.f
hdl/r332d_pkg.sv
hdl/r332d_quant.sv
hdl/rgba_to_rgb332_dither_unit.sv
dv/tb.sv
